// ===== hdl/rtp_header_parser_assert.svh =====
// ----------------------------------------------------------------------------
// RTP header parser assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_ASSERT_SVH
`define RTP_HEADER_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// check outside of reset
`define RHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define RHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RHP_ASSERT(lbl, prop, msg)
`define RHP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/rhp_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP header parser package
// Word types, status codes and layout constants shared by the parser modules.
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam int unsigned RHP_MAX_PACKET_BYTES = 65535;

  localparam int unsigned RHP_POS_W   = 16;
  localparam int unsigned RHP_REQ_W   = 19;
  localparam int unsigned RHP_FIXED_N = 12;

  localparam logic [RHP_POS_W-1:0] RHP_FIXED_BYTES = 16'd12;
  localparam logic [RHP_REQ_W-1:0] RHP_REQ_RESET   = 19'd12;
  localparam logic [RHP_REQ_W-1:0] RHP_EXT_HDR     = 19'd4;
  localparam logic [1:0]           RHP_RTP_VERSION = 2'd2;

  // length word sits at bytes 2 and 3 of the extension header
  localparam logic [1:0] RHP_EXT_LEN_HI = 2'd2;
  localparam logic [1:0] RHP_EXT_LEN_LO = 2'd3;

  localparam logic [1:0] RHP_ST_OK     = 2'd0;
  localparam logic [1:0] RHP_ST_SHORT  = 2'd1;
  localparam logic [1:0] RHP_ST_BADVER = 2'd2;
  localparam logic [1:0] RHP_ST_TRUNC  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rhp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  csrc_total;
    logic        marker_flag;
    logic [6:0]  payload_kind;
    logic [15:0] sequence_res;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [15:0] header_length;
    logic [15:0] payload_length;
  } rhp_out_t;

  // handshake between the input stage and the rest of the pipe
  typedef struct packed {
    logic process;
    logic last;
  } rhp_ctl_t;

  // packet state as it stands after the current byte
  typedef struct packed {
    logic [RHP_POS_W-1:0]               count;
    logic [RHP_FIXED_N-1:0][7:0]        hdr;
    logic [RHP_REQ_W-1:0]               req;
  } rhp_snap_t;

endpackage

// ===== hdl/rhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// RTP header parser input stage
// Registers the incoming word and decides when it may be consumed.
// ----------------------------------------------------------------------------
module rhp_in_stage
  import rhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  rhp_in_t in_data,
  input  logic    out_free,
  output rhp_in_t word,
  output rhp_ctl_t ctl
);

  logic    valid_r, valid_nxt;
  rhp_in_t word_r;
  logic    process;
  logic    accept;

  // a final byte needs a free result slot; other bytes always go through
  assign process  = valid_r && (!word_r.last_byte || out_free);
  assign in_stall = valid_r && !process;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (process) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_data;
    end
  end

  assign word        = word_r;
  assign ctl.process = process;
  assign ctl.last    = word_r.last_byte;

endmodule

// ===== hdl/rhp_track.sv =====
// ----------------------------------------------------------------------------
// RTP header parser packet tracker
// Counts bytes, captures the fixed header and the extension length word,
// and keeps the number of header bytes the packet must hold.
// ----------------------------------------------------------------------------
`include "rtp_header_parser_assert.svh"

module rhp_track
  import rhp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = RHP_MAX_PACKET_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rhp_ctl_t  ctl,
  input  rhp_in_t   word,
  output rhp_snap_t snap
);

  localparam logic [RHP_POS_W-1:0] MaxPos = RHP_POS_W'(MAX_PACKET_BYTES);

  logic [RHP_POS_W-1:0]        pos_r, pos_nxt;
  logic [7:0]                  ext_hi_r, ext_hi_nxt;
  logic [RHP_REQ_W-1:0]        req_r, req_nxt;
  logic [RHP_FIXED_N-1:0][7:0] store_r;
  logic [RHP_FIXED_N-1:0][7:0] hdr_nxt;

  logic                        live;
  logic                        wr;
  logic                        in_fixed;
  logic [3:0]                  cc;
  logic                        xbit;
  logic [RHP_POS_W-3:0]        ext_len_word;
  logic                        ext_word_hit;
  logic [RHP_POS_W-1:0]        count;

  assign live     = pos_r < MaxPos;
  assign wr       = ctl.process && live;
  assign in_fixed = pos_r < RHP_FIXED_BYTES;

  always_comb begin
    for (int i = 0; i < RHP_FIXED_N; i++) begin
      hdr_nxt[i] = store_r[i];
      if (wr && in_fixed && (pos_r[3:0] == 4'(i))) begin
        hdr_nxt[i] = word.data_byte;
      end
    end
  end

  assign cc   = hdr_nxt[0][3:0];
  assign xbit = hdr_nxt[0][4];

  // extension header starts at word 3 + CC
  assign ext_len_word = (RHP_POS_W-2)'(RHP_FIXED_N / 4) + (RHP_POS_W-2)'(cc);
  assign ext_word_hit = xbit && !in_fixed && (pos_r[RHP_POS_W-1:2] == ext_len_word);

  always_comb begin
    ext_hi_nxt = ext_hi_r;
    req_nxt    = req_r;
    if (pos_r == RHP_FIXED_BYTES - 16'd1) begin
      req_nxt = RHP_REQ_RESET + {13'd0, cc, 2'b00} + (xbit ? RHP_EXT_HDR : '0);
    end else if (ext_word_hit && pos_r[1:0] == RHP_EXT_LEN_HI) begin
      ext_hi_nxt = word.data_byte;
    end else if (ext_word_hit && pos_r[1:0] == RHP_EXT_LEN_LO) begin
      req_nxt = req_r + {1'b0, ext_hi_r, word.data_byte, 2'b00};
    end
    if (!wr) begin
      ext_hi_nxt = ext_hi_r;
      req_nxt    = req_r;
    end
  end

  assign pos_nxt = live ? pos_r + 16'd1 : pos_r;
  assign count   = wr ? pos_nxt : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ext_hi_r <= '0;
      req_r    <= RHP_REQ_RESET;
    end else if (ctl.process) begin
      if (ctl.last) begin
        pos_r    <= '0;
        ext_hi_r <= '0;
        req_r    <= RHP_REQ_RESET;
      end else begin
        pos_r    <= count;
        ext_hi_r <= ext_hi_nxt;
        req_r    <= req_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr && in_fixed) begin
      store_r <= hdr_nxt;
    end
  end

  assign snap.count = count;
  assign snap.hdr   = hdr_nxt;
  assign snap.req   = req_nxt;

  `RHP_ASSERT(a_pos_bound, pos_r <= MaxPos, "byte position beyond packet bound")
  `RHP_ASSERT(a_last_clears, ctl.process && ctl.last |=> pos_r == '0 && req_r == RHP_REQ_RESET,
              "packet state not cleared after final byte")
  `RHP_ASSERT(a_req_floor, req_r >= RHP_REQ_RESET, "required header below fixed size")

endmodule

// ===== hdl/rhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// RTP header parser result stage
// Decodes the header fields and status on the final byte and holds the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rhp_out_stage
  import rhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rhp_ctl_t  ctl,
  input  rhp_snap_t snap,
  input  logic      out_stall,
  output logic      out_valid,
  output rhp_out_t  out_data,
  output logic      out_free
);

  logic                 valid_r, valid_nxt;
  rhp_out_t             res_r, res_nxt;
  logic                 load;
  logic [RHP_REQ_W:0]   diff;
  logic [7:0]           h0;

  assign out_free = !valid_r || !out_stall;
  assign load     = ctl.process && ctl.last;
  assign h0       = snap.hdr[0];

  // borrow out of count minus required bytes flags a truncated header
  assign diff = {4'd0, snap.count} - {1'b0, snap.req};

  always_comb begin
    res_nxt = '0;
    if (snap.count < RHP_FIXED_BYTES) begin
      res_nxt.status = RHP_ST_SHORT;
    end else begin
      res_nxt.padding_flag   = h0[5];
      res_nxt.extension_flag = h0[4];
      res_nxt.csrc_total     = h0[3:0];
      res_nxt.marker_flag    = snap.hdr[1][7];
      res_nxt.payload_kind   = snap.hdr[1][6:0];
      res_nxt.sequence_res   = {snap.hdr[2], snap.hdr[3]};
      res_nxt.time_stamp     = {snap.hdr[4], snap.hdr[5], snap.hdr[6], snap.hdr[7]};
      res_nxt.source_id      = {snap.hdr[8], snap.hdr[9], snap.hdr[10], snap.hdr[11]};
      if (h0[7:6] != RHP_RTP_VERSION) begin
        res_nxt.status = RHP_ST_BADVER;
      end else if (diff[RHP_REQ_W]) begin
        res_nxt.status = RHP_ST_TRUNC;
      end else begin
        res_nxt.status         = RHP_ST_OK;
        res_nxt.header_length  = snap.req[15:0];
        res_nxt.payload_length = diff[15:0];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

// ===== hdl/rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// RTP header parser
// Byte-stream parser for the RFC 3550 fixed, CSRC and extension header.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) carries one packet byte per
// word, in network order, with last_byte set on the final byte. The output
// channel (out_valid / out_stall / out_data) carries one result word per
// packet: status, fixed-header fields, header length and payload length.
// Bytes past MAX_PACKET_BYTES are neither counted nor captured.
//
// Throughput: one byte per cycle unless a final byte waits. A final byte is
// held in the input register, then its result is loaded into the result
// register by the decode logic.
// While the receiver stalls, the held result stays on out_data and non-final
// bytes keep flowing; only a final byte waits, which raises in_stall.
// Reset (rst_n low, synchronous) empties both registers and returns the byte
// count, extension word and required header size to the start of a packet.
// ----------------------------------------------------------------------------
`include "rtp_header_parser_assert.svh"

module rtp_header_parser
  import rhp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = RHP_MAX_PACKET_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rhp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rhp_out_t out_data
);

  rhp_in_t   word;
  rhp_ctl_t  ctl;
  rhp_snap_t snap;
  logic      out_free;

  rhp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .word     (word),
    .ctl      (ctl)
  );

  rhp_track #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .word  (word),
    .snap  (snap)
  );

  rhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .snap      (snap),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_free  (out_free)
  );

  `RHP_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall,
              "input stalled without a blocked result")
  `RHP_ASSERT(a_ok_hdr_len, out_valid && out_data.status == RHP_ST_OK |->
              out_data.header_length >= RHP_FIXED_BYTES, "ok result with short header length")
  `RHP_ASSERT(a_short_zero, out_valid && out_data.status == RHP_ST_SHORT |->
              out_data.header_length == '0 && out_data.source_id == '0,
              "short packet result carries field data")

endmodule

// ===== tb/rtp_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// RTP header parser testbench
// Feeds RTP packets one byte per word and checks every per-packet result word
// against a byte-level header predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module rtp_header_parser_tb;
  import rhp_pkg::*;

  localparam int          CLK_PERIOD      = 12;
  localparam int unsigned CSRC_WORD_BYTES = 4;
  localparam int unsigned EXT_WORD_BYTES  = 4;
  localparam int unsigned FIXED_LAST      = RHP_FIXED_N - 1;
  localparam int unsigned RANDOM_BYTES    = 690;
  localparam int          SETTLE_CYCLES   = 10;

  class rtp_header_board;
    logic [15:0] byte_count;
    logic [7:0]  fixed_hdr [RHP_FIXED_N];
    logic [15:0] ext_length;
    logic [18:0] header_need;
    rhp_out_t    pending_headers [$];
    int          errors;
    int          status_count [4];

    function new();
      foreach (fixed_hdr[i]) fixed_hdr[i] = '0;
      foreach (status_count[i]) status_count[i] = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_count  = '0;
      ext_length  = '0;
      header_need = RHP_REQ_RESET;
    endfunction

    // Advance the packet state by one accepted byte; on the final byte queue
    // the header result it must produce.
    function void take_byte(rhp_in_t word);
      int unsigned pos;
      int unsigned ext_at;
      rhp_out_t    hdr_fields;
      pos = byte_count;
      if (pos < RHP_MAX_PACKET_BYTES) begin
        if (pos < RHP_FIXED_N) fixed_hdr[pos] = word.data_byte;
        ext_at = RHP_FIXED_N + CSRC_WORD_BYTES * fixed_hdr[0][3:0];
        if (pos == FIXED_LAST) begin
          header_need = 19'(ext_at + (fixed_hdr[0][4] ? RHP_EXT_HDR : 0));
        end else if (pos > FIXED_LAST && fixed_hdr[0][4]) begin
          if (pos == ext_at + RHP_EXT_LEN_HI) begin
            ext_length = {word.data_byte, 8'h00};
          end else if (pos == ext_at + RHP_EXT_LEN_LO) begin
            ext_length[7:0] = word.data_byte;
            header_need = 19'(ext_at + RHP_EXT_HDR + EXT_WORD_BYTES * ext_length);
          end
        end
        byte_count = 16'(pos + 1);
      end
      if (word.last_byte) begin
        hdr_fields = '0;
        if (byte_count < RHP_FIXED_BYTES) begin
          hdr_fields.status = RHP_ST_SHORT;
        end else begin
          if (fixed_hdr[0][7:6] != RHP_RTP_VERSION) hdr_fields.status = RHP_ST_BADVER;
          else if (byte_count < header_need) hdr_fields.status = RHP_ST_TRUNC;
          else hdr_fields.status = RHP_ST_OK;
          hdr_fields.padding_flag   = fixed_hdr[0][5];
          hdr_fields.extension_flag = fixed_hdr[0][4];
          hdr_fields.csrc_total     = fixed_hdr[0][3:0];
          hdr_fields.marker_flag    = fixed_hdr[1][7];
          hdr_fields.payload_kind   = fixed_hdr[1][6:0];
          hdr_fields.sequence_res   = {fixed_hdr[2], fixed_hdr[3]};
          hdr_fields.time_stamp     = {fixed_hdr[4], fixed_hdr[5], fixed_hdr[6], fixed_hdr[7]};
          hdr_fields.source_id      = {fixed_hdr[8], fixed_hdr[9], fixed_hdr[10], fixed_hdr[11]};
          if (hdr_fields.status == RHP_ST_OK) begin
            hdr_fields.header_length  = header_need[15:0];
            hdr_fields.payload_length = byte_count - header_need[15:0];
          end
        end
        pending_headers.push_back(hdr_fields);
        restart();
      end
    endfunction

    function void match_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(rhp_out_t got);
      rhp_out_t want;
      if (pending_headers.size() == 0) begin
        errors++;
        $display("%0t: result word with no packet pending, expected none, actual 0x%0h",
                 $time, got);
        return;
      end
      want = pending_headers.pop_front();
      status_count[want.status]++;
      match_field("status", 32'(want.status), 32'(got.status));
      match_field("padding_flag", 32'(want.padding_flag), 32'(got.padding_flag));
      match_field("extension_flag", 32'(want.extension_flag), 32'(got.extension_flag));
      match_field("csrc_total", 32'(want.csrc_total), 32'(got.csrc_total));
      match_field("marker_flag", 32'(want.marker_flag), 32'(got.marker_flag));
      match_field("payload_kind", 32'(want.payload_kind), 32'(got.payload_kind));
      match_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
      match_field("time_stamp", want.time_stamp, got.time_stamp);
      match_field("source_id", want.source_id, got.source_id);
      match_field("header_length", 32'(want.header_length), 32'(got.header_length));
      match_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rhp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rhp_out_t out_data;

  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  int         bytes_sent = 0;
  int         packets_sent = 0;
  logic [7:0] pkt [$];
  rtp_header_board board;

  rtp_header_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    rhp_in_t word;
    word.data_byte = value;
    word.last_byte = is_last;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall);
    board.take_byte(word);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  // Build a packet: fixed header with random fields, CSRC list, optional
  // extension (length word plus ext_body bytes), then payload.
  task automatic make_rtp(input logic [1:0] ver, input logic [3:0] cc, input bit ext,
                          input logic [15:0] ext_words, input int ext_body,
                          input int payload);
    logic pad;
    pad = 1'($urandom_range(1));
    pkt.delete();
    pkt.push_back({ver, pad, ext, cc});
    repeat (FIXED_LAST) pkt.push_back(rand_byte());
    repeat (CSRC_WORD_BYTES * cc) pkt.push_back(rand_byte());
    if (ext) begin
      pkt.push_back(rand_byte());
      pkt.push_back(rand_byte());
      pkt.push_back(ext_words[15:8]);
      pkt.push_back(ext_words[7:0]);
      repeat (ext_body) pkt.push_back(rand_byte());
    end
    repeat (payload) pkt.push_back(rand_byte());
  endtask

  task automatic cut_packet(input int keep);
    while (pkt.size() > keep) void'(pkt.pop_back());
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (board.pending_headers.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    int n;
    // lone final byte, then one byte short of the fixed header
    pkt.delete();
    pkt.push_back(8'h80);
    send_packet();
    make_rtp(RHP_RTP_VERSION, 0, 0, 0, 0, 0);
    cut_packet(FIXED_LAST);
    send_packet();
    // fixed header only, fields at top and then bottom values
    make_rtp(RHP_RTP_VERSION, 0, 0, 0, 0, 0);
    for (n = 1; n < RHP_FIXED_N; n++) pkt[n] = 8'hFF;
    pkt[0] = 8'hA0;
    send_packet();
    pkt.delete();
    pkt.push_back(8'h80);
    repeat (FIXED_LAST) pkt.push_back(8'h00);
    send_packet();
    // every version other than 2
    for (n = 0; n < 4; n++) begin
      if (n != RHP_RTP_VERSION) begin
        make_rtp(2'(n), 4'($urandom_range(15)), 1'($urandom_range(1)), 0, 0, 4);
        send_packet();
      end
    end
    make_rtp(2'd3, 15, 1, 16'hFFFF, 0, 0);
    pkt[0] = 8'hFF;
    send_packet();
    // full CSRC list announced but missing
    make_rtp(RHP_RTP_VERSION, 15, 0, 0, 0, 0);
    cut_packet(RHP_FIXED_N);
    send_packet();
    // packet ends before the extension length word, then after its high byte
    make_rtp(RHP_RTP_VERSION, 0, 1, 1, 4, 0);
    cut_packet(RHP_FIXED_N + 2);
    send_packet();
    make_rtp(RHP_RTP_VERSION, 0, 1, 1, 4, 0);
    cut_packet(RHP_FIXED_N + 3);
    send_packet();
    // empty extension, largest length word, full CSRC list with extension
    make_rtp(RHP_RTP_VERSION, 0, 1, 0, 0, 3);
    send_packet();
    make_rtp(RHP_RTP_VERSION, 1, 1, 16'hFFFF, 8, 2);
    send_packet();
    make_rtp(RHP_RTP_VERSION, 15, 1, 1, 4, 5);
    send_packet();
    make_rtp(RHP_RTP_VERSION, 2, 1, 2, 8, 0);
    send_packet();
  endtask

  task automatic send_random_packet();
    int         pick;
    int         cc;
    int         words;
    bit         ext;
    logic [1:0] ver;
    pick  = $urandom_range(99);
    cc    = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2);
    ext   = ($urandom_range(99) < 40);
    words = $urandom_range(3);
    if (pick < 70) begin
      make_rtp(RHP_RTP_VERSION, 4'(cc), ext, 16'(words), EXT_WORD_BYTES * words,
               $urandom_range(24));
    end else if (pick < 82) begin
      // well-formed start, cut anywhere
      if ($urandom_range(1)) words = $urandom_range(65535);
      make_rtp(RHP_RTP_VERSION, 4'(cc), ext, 16'(words), $urandom_range(8),
               $urandom_range(8));
      cut_packet($urandom_range(1, pkt.size()));
    end else if (pick < 90) begin
      ver = 2'($urandom_range(2));
      if (ver == RHP_RTP_VERSION) ver = 2'd3;
      make_rtp(ver, 4'(cc), ext, 16'(words), EXT_WORD_BYTES * words, $urandom_range(12));
    end else begin
      pkt.delete();
      repeat ($urandom_range(1, 20)) pkt.push_back(rand_byte());
    end
    send_packet();
  endtask

  initial begin
    int phase;
    int first_byte;
    int first_packet;
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    hold_until_drained();
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 18 : (phase == 1) ? 50 : 0;
      recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 18 : 0;
      first_byte   = bytes_sent;
      first_packet = packets_sent;
      while (bytes_sent - first_byte < RANDOM_BYTES / 3 || packets_sent - first_packet < 6)
        send_random_packet();
      hold_until_drained();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Parsed %0d packets in %0d bytes under three sender and receiver stall mixes",
             packets_sent, bytes_sent);
    $display("Result status mix: ok %0d, short %0d, bad version %0d, truncated %0d",
             board.status_count[RHP_ST_OK], board.status_count[RHP_ST_SHORT],
             board.status_count[RHP_ST_BADVER], board.status_count[RHP_ST_TRUNC]);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("Timeout with %0d results still pending", board.pending_headers.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
